// ===== hdl/tid_pkg.sv =====
`default_nettype none
package tid_pkg;

  typedef enum logic [1:0] {
    CMD_EXPAND = 2'd0,
    CMD_SHIFT  = 2'd1,
    CMD_BRANCH = 2'd2,
    CMD_SHORT  = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_LSL = 2'd0;
  localparam logic [1:0] ST_LSR = 2'd1;
  localparam logic [1:0] ST_ASR = 2'd2;
  localparam logic [1:0] ST_ROR = 2'd3;

  localparam logic [2:0] SK_LSL = 3'd0;
  localparam logic [2:0] SK_LSR = 3'd1;
  localparam logic [2:0] SK_ASR = 3'd2;
  localparam logic [2:0] SK_ROR = 3'd3;
  localparam logic [2:0] SK_RRX = 3'd4;

  localparam logic [4:0] ShortMax = 5'd24;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        top_bit;
    logic [2:0]  imm3;
    logic [7:0]  imm8;
    logic [1:0]  imm2;
    logic [1:0]  shift_type;
    logic        jump1;
    logic        jump2;
    logic [9:0]  imm10;
    logic [10:0] imm11;
    logic [23:0] short_imm;
    logic [4:0]  short_size;
  } in_t;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  shift_kind;
    logic [5:0]  shift_amount;
  } out_t;

  // after field decode
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] fixed_val;
    logic        rot_en;
    logic [7:0]  rot_base;
    logic [4:0]  rot_amt;
    logic [2:0]  kind;
    logic [5:0]  amount;
    logic [23:0] field;
    logic [4:0]  size;
  } s1_t;

  // after rotate and extend
  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] fixed_val;
    logic        rot_en;
    logic [31:0] rot_val;
    logic [31:0] short_val;
    logic [2:0]  kind;
    logic [5:0]  amount;
  } s2_t;

endpackage
`default_nettype wire

// ===== hdl/tid_decode.sv =====
`default_nettype none
module tid_decode (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             valid_i,
  output logic            ready_o,
  input  wire tid_pkg::in_t req_i,
  output logic            valid_o,
  input  wire             ready_i,
  output tid_pkg::s1_t    data_o
);
  import tid_pkg::*;

  logic        valid_q;
  s1_t         data_q, data_d;
  logic [4:0]  imm5;
  logic        i1, i2;
  logic [4:0]  size_sat;
  logic [23:0] mask;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    imm5     = {req_i.imm3, req_i.imm2};
    i1       = ~(req_i.jump1 ^ req_i.top_bit);
    i2       = ~(req_i.jump2 ^ req_i.top_bit);
    size_sat = (req_i.short_size > ShortMax) ? ShortMax : req_i.short_size;
    mask     = (24'd1 << size_sat) - 24'd1;

    data_d          = '0;
    data_d.cmd      = cmd_e'(req_i.cmd);
    data_d.rot_base = {1'b1, req_i.imm8[6:0]};
    data_d.rot_amt  = {req_i.top_bit, req_i.imm3, req_i.imm8[7]};
    data_d.field    = req_i.short_imm & mask;
    data_d.size     = size_sat;

    case (cmd_e'(req_i.cmd))
      CMD_EXPAND: begin
        if ({req_i.top_bit, req_i.imm3[2]} == 2'b00) begin
          case (req_i.imm3[1:0])
            2'd0:    data_d.fixed_val = {24'd0, req_i.imm8};
            2'd1:    data_d.fixed_val = {8'd0, req_i.imm8, 8'd0, req_i.imm8};
            2'd2:    data_d.fixed_val = {req_i.imm8, 8'd0, req_i.imm8, 8'd0};
            default: data_d.fixed_val = {4{req_i.imm8}};
          endcase
        end else begin
          data_d.rot_en = 1'b1;
        end
      end
      CMD_SHIFT: begin
        case (req_i.shift_type)
          ST_LSL: begin
            data_d.kind   = SK_LSL;
            data_d.amount = {1'b0, imm5};
          end
          ST_LSR: begin
            data_d.kind   = SK_LSR;
            data_d.amount = (imm5 == 5'd0) ? 6'd32 : {1'b0, imm5};
          end
          ST_ASR: begin
            data_d.kind   = SK_ASR;
            data_d.amount = (imm5 == 5'd0) ? 6'd32 : {1'b0, imm5};
          end
          default: begin
            data_d.kind   = (imm5 == 5'd0) ? SK_RRX : SK_ROR;
            data_d.amount = (imm5 == 5'd0) ? 6'd1 : {1'b0, imm5};
          end
        endcase
      end
      CMD_BRANCH: begin
        data_d.fixed_val = {{8{req_i.top_bit}}, i1, i2, req_i.imm10, req_i.imm11, 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tid_extend.sv =====
`default_nettype none
module tid_extend (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             valid_i,
  output logic            ready_o,
  input  wire tid_pkg::s1_t data_i,
  output logic            valid_o,
  input  wire             ready_i,
  output tid_pkg::s2_t    data_o
);
  import tid_pkg::*;

  logic        valid_q;
  s2_t         data_q, data_d;
  logic [31:0] rot_dbl;
  logic [4:0]  sign_idx;
  logic        sign;
  logic [5:0]  fill_sh;
  logic [31:0] fill;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    rot_dbl  = 32'({24'd0, data_i.rot_base, 24'd0, data_i.rot_base} >> data_i.rot_amt);
    sign_idx = data_i.size - 5'd1;
    sign     = (data_i.size != 5'd0) && data_i.field[sign_idx];
    fill_sh  = {1'b0, data_i.size} + 6'd1;
    fill     = 32'hFFFF_FFFF << fill_sh;

    data_d           = '0;
    data_d.cmd       = data_i.cmd;
    data_d.fixed_val = data_i.fixed_val;
    data_d.rot_en    = data_i.rot_en;
    data_d.rot_val   = rot_dbl;
    data_d.short_val = {7'd0, data_i.field, 1'b0} | (sign ? fill : 32'd0);
    data_d.kind      = data_i.kind;
    data_d.amount    = data_i.amount;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tid_select.sv =====
`default_nettype none
module tid_select (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             valid_i,
  output logic            ready_o,
  input  wire tid_pkg::s2_t data_i,
  output logic            valid_o,
  input  wire             ready_i,
  output tid_pkg::out_t   rsp_o
);
  import tid_pkg::*;

  logic valid_q;
  out_t rsp_q, rsp_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

  always_comb begin
    rsp_d              = '0;
    rsp_d.shift_kind   = data_i.kind;
    rsp_d.shift_amount = data_i.amount;
    case (data_i.cmd)
      CMD_EXPAND: rsp_d.value = data_i.rot_en ? data_i.rot_val : data_i.fixed_val;
      CMD_SHIFT:  rsp_d.value = 32'd0;
      CMD_BRANCH: rsp_d.value = data_i.fixed_val;
      default:    rsp_d.value = data_i.short_val;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      rsp_q <= rsp_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/thumb_immediate_decoder.sv =====
`default_nettype none
// Thumb-2 immediate decoder: each request carries one instruction's immediate
// fields and a cmd code (expand modified immediate, decode immediate shift,
// build wide branch offset, sign-extend short immediate) and yields exactly one
// response. Three register stages (field decode, rotate/extend, select); while
// the output is not stalled, a new request is taken every cycle. Each stage
// holds its item while the next one is full and stalled, so back-pressure
// loses nothing.
module thumb_immediate_decoder (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  wire tid_pkg::in_t in_req_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output tid_pkg::out_t   out_rsp_o
);
  import tid_pkg::*;

  logic s1_valid, s1_ready;
  s1_t  s1_data;
  logic s2_valid, s2_ready;
  s2_t  s2_data;

  tid_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (in_req_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  tid_extend u_extend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  tid_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rsp_o   (out_rsp_o)
  );

endmodule
`default_nettype wire

// ===== sim/thumb_immediate_decoder_checker.sv =====
`timescale 1ns / 1ps
module thumb_immediate_decoder_checker (
  input  wire           clk_i,
  input  wire           rst_ni,
  input  wire           in_valid_i,
  input  wire           in_ready_i,
  input  tid_pkg::in_t  in_req_i,
  input  wire           out_valid_i,
  input  wire           out_ready_i,
  input  tid_pkg::out_t out_rsp_i,
  output int            mismatch_count_o,
  output int            outstanding_o
);
  import tid_pkg::*;

  out_t decoded_q[$];
  out_t want;
  int   mismatches = 0;

  function automatic logic [31:0] expand_imm(logic i_bit, logic [2:0] imm3, logic [7:0] imm8);
    logic [11:0] imm12;
    logic [31:0] base;
    logic [4:0]  rot;
    imm12 = {i_bit, imm3, imm8};
    if (imm12[11:10] == 2'b00) begin
      case (imm12[9:8])
        2'd0: return {24'h0, imm8};
        2'd1: return {8'h0, imm8, 8'h0, imm8};
        2'd2: return {imm8, 8'h0, imm8, 8'h0};
        default: return {4{imm8}};
      endcase
    end
    base = {24'h0, 1'b1, imm8[6:0]};
    rot  = imm12[11:7];
    return (base >> rot) | (base << (6'd32 - {1'b0, rot}));
  endfunction

  function automatic void decode_shift(input logic [1:0] stype, input logic [4:0] imm5,
                                       output logic [2:0] kind, output logic [5:0] amount);
    case (stype)
      ST_LSL: begin
        kind   = SK_LSL;
        amount = {1'b0, imm5};
      end
      ST_LSR, ST_ASR: begin
        kind   = (stype == ST_LSR) ? SK_LSR : SK_ASR;
        amount = (imm5 == 5'd0) ? 6'd32 : {1'b0, imm5};
      end
      default: begin
        kind   = (imm5 == 5'd0) ? SK_RRX : SK_ROR;
        amount = (imm5 == 5'd0) ? 6'd1 : {1'b0, imm5};
      end
    endcase
  endfunction

  function automatic logic [31:0] branch_offset(logic s, logic j1, logic j2,
                                                logic [9:0] imm10, logic [10:0] imm11);
    logic i1;
    logic i2;
    i1 = ~(j1 ^ s);
    i2 = ~(j2 ^ s);
    return {{7{s}}, s, i1, i2, imm10, imm11, 1'b0};
  endfunction

  function automatic logic [31:0] short_extend(logic [23:0] imm, logic [4:0] size);
    logic [4:0]  width;
    logic [31:0] mask;
    logic [31:0] field;
    if (size == 5'd0) return 32'h0;
    width = (size > ShortMax) ? ShortMax : size;
    mask  = (32'd1 << width) - 32'd1;
    field = {8'h0, imm} & mask;
    if (field[width - 5'd1]) return (field << 1) | ~((32'd1 << (width + 5'd1)) - 32'd1);
    return field << 1;
  endfunction

  function automatic out_t decode_fields(in_t req);
    out_t        rsp;
    logic [2:0]  kind;
    logic [5:0]  amount;
    rsp = '0;
    case (cmd_e'(req.cmd))
      CMD_EXPAND: rsp.value = expand_imm(req.top_bit, req.imm3, req.imm8);
      CMD_SHIFT: begin
        decode_shift(req.shift_type, {req.imm3, req.imm2}, kind, amount);
        rsp.shift_kind   = kind;
        rsp.shift_amount = amount;
      end
      CMD_BRANCH: rsp.value = branch_offset(req.top_bit, req.jump1, req.jump2,
                                            req.imm10, req.imm11);
      default: rsp.value = short_extend(req.short_imm, req.short_size);
    endcase
    return rsp;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual %h/%0d/%0d", $time,
                   out_rsp_i.value, out_rsp_i.shift_kind, out_rsp_i.shift_amount);
          mismatches++;
        end else begin
          want = decoded_q.pop_front();
          check_field("value", want.value, out_rsp_i.value);
          check_field("shift_kind", {29'h0, want.shift_kind}, {29'h0, out_rsp_i.shift_kind});
          check_field("shift_amount", {26'h0, want.shift_amount},
                      {26'h0, out_rsp_i.shift_amount});
        end
      end
      if (in_valid_i && in_ready_i) decoded_q.push_back(decode_fields(in_req_i));
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= decoded_q.size();
  end

endmodule

// ===== sim/thumb_immediate_decoder_test.sv =====
`timescale 1ns / 1ps
module thumb_immediate_decoder_test;
  import tid_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int TailCycles = 12;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  in_t  req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  out_t rsp;

  int   mismatch_count;
  int   outstanding;
  int   cycles  = 0;
  bit   idle_on = 1'b0;

  thumb_immediate_decoder u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_req_i    (req),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_rsp_o   (rsp)
  );

  thumb_immediate_decoder_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (req_valid),
    .in_ready_i       (req_ready),
    .in_req_i         (req),
    .out_valid_i      (rsp_valid),
    .out_ready_i      (rsp_ready),
    .out_rsp_i        (rsp),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
    end
  end

  function automatic in_t rand_req();
    in_t r;
    r.cmd        = 2'($urandom_range(0, 3));
    r.top_bit    = 1'($urandom_range(0, 1));
    r.imm3       = 3'($urandom_range(0, 7));
    r.imm8       = 8'($urandom_range(0, 255));
    r.imm2       = 2'($urandom_range(0, 3));
    r.shift_type = 2'($urandom_range(0, 3));
    r.jump1      = 1'($urandom_range(0, 1));
    r.jump2      = 1'($urandom_range(0, 1));
    r.imm10      = 10'($urandom_range(0, 1023));
    r.imm11      = 11'($urandom_range(0, 2047));
    r.short_imm  = 24'($urandom());
    r.short_size = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                               : 5'($urandom_range(1, 24));
    if (r.cmd == CMD_SHIFT && $urandom_range(0, 3) == 0) begin
      r.imm3 = 3'd0;
      r.imm2 = 2'd0;
    end
    return r;
  endfunction

  function automatic in_t expand_req(logic i_bit, logic [2:0] imm3, logic [7:0] imm8);
    in_t r;
    r         = rand_req();
    r.cmd     = CMD_EXPAND;
    r.top_bit = i_bit;
    r.imm3    = imm3;
    r.imm8    = imm8;
    return r;
  endfunction

  function automatic in_t shift_req(logic [1:0] stype, logic [4:0] imm5);
    in_t r;
    r            = rand_req();
    r.cmd        = CMD_SHIFT;
    r.shift_type = stype;
    r.imm3       = imm5[4:2];
    r.imm2       = imm5[1:0];
    return r;
  endfunction

  function automatic in_t branch_req(logic s, logic j1, logic j2,
                                     logic [9:0] imm10, logic [10:0] imm11);
    in_t r;
    r         = rand_req();
    r.cmd     = CMD_BRANCH;
    r.top_bit = s;
    r.jump1   = j1;
    r.jump2   = j2;
    r.imm10   = imm10;
    r.imm11   = imm11;
    return r;
  endfunction

  function automatic in_t short_req(logic [23:0] imm, logic [4:0] size);
    in_t r;
    r            = rand_req();
    r.cmd        = CMD_SHORT;
    r.short_imm  = imm;
    r.short_size = size;
    return r;
  endfunction

  task automatic send_req(in_t item);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(expand_req(1'b0, 3'd0, 8'hAB));
    send_req(expand_req(1'b0, 3'd1, 8'hAB));
    send_req(expand_req(1'b0, 3'd2, 8'h00));
    send_req(expand_req(1'b0, 3'd3, 8'hFF));
    send_req(expand_req(1'b0, 3'd4, 8'h00));
    send_req(expand_req(1'b1, 3'd7, 8'hFF));
    send_req(shift_req(ST_LSL, 5'd0));
    send_req(shift_req(ST_LSL, 5'd31));
    send_req(shift_req(ST_LSR, 5'd0));
    send_req(shift_req(ST_ASR, 5'd0));
    send_req(shift_req(ST_ASR, 5'd31));
    send_req(shift_req(ST_ROR, 5'd0));
    send_req(shift_req(ST_ROR, 5'd1));
    send_req(branch_req(1'b0, 1'b0, 1'b0, 10'h000, 11'h000));
    send_req(branch_req(1'b1, 1'b1, 1'b1, 10'h3FF, 11'h7FF));
    send_req(branch_req(1'b1, 1'b0, 1'b0, 10'h000, 11'h000));
    send_req(branch_req(1'b0, 1'b1, 1'b1, 10'h3FF, 11'h7FF));
    send_req(short_req(24'hFFFFFF, 5'd1));
    send_req(short_req(24'h800000, 5'd24));
    send_req(short_req(24'hFFFFFF, 5'd0));
    send_req(short_req(24'hFFFFFF, 5'd31));
    send_req(short_req(24'hFFF7FF, 5'd12));
    send_req(short_req(24'h000010, 5'd5));

    idle_on = 1'b1;
    repeat (300) send_req(rand_req());
    // hold off until the pipe is empty
    wait_drained();
    repeat (250) send_req(rand_req());
    idle_on = 1'b0;
    repeat (200) send_req(rand_req());

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
